// ===== sv/dsfe_pkg.sv =====
// ----------------------------------------------------------------------------
// dsfe_pkg
// shared types and constants for the shortest float encoder
// ----------------------------------------------------------------------------
package dsfe_pkg;

    // encoding kinds
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_ZERO   = 2'd0;
    localparam t_kind KIND_HALF   = 2'd1;
    localparam t_kind KIND_SINGLE = 2'd2;
    localparam t_kind KIND_DOUBLE = 2'd3;

    // register indexes
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_TAG_ZERO   = 2'd0;
    localparam t_cfg_idx CFG_TAG_HALF   = 2'd1;
    localparam t_cfg_idx CFG_TAG_SINGLE = 2'd2;
    localparam t_cfg_idx CFG_TAG_DOUBLE = 2'd3;

    localparam logic [7:0] TAG_ZERO_RST   = 8'd0;
    localparam logic [7:0] TAG_HALF_RST   = 8'd1;
    localparam logic [7:0] TAG_SINGLE_RST = 8'd2;
    localparam logic [7:0] TAG_DOUBLE_RST = 8'd3;

    // biased exponent windows
    localparam logic [10:0] HALF_EXP_MIN   = 11'd1009;
    localparam logic [10:0] HALF_EXP_MAX   = 11'd1038;
    localparam logic [10:0] HALF_REBIAS    = 11'd1008;
    localparam logic [10:0] SINGLE_EXP_MIN = 11'd897;
    localparam logic [10:0] SINGLE_EXP_MAX = 11'd1150;
    localparam logic [10:0] SINGLE_REBIAS  = 11'd896;

    localparam logic [15:0] HALF_NAN     = 16'h7D00;
    localparam logic [15:0] HALF_NEG_INF = 16'hFC00;
    localparam logic [15:0] HALF_POS_INF = 16'h7C00;

    localparam logic [3:0] PBYTES_ZERO   = 4'd0;
    localparam logic [3:0] PBYTES_HALF   = 4'd2;
    localparam logic [3:0] PBYTES_SINGLE = 4'd4;
    localparam logic [3:0] PBYTES_DOUBLE = 4'd8;

    typedef struct packed {
        logic abs_zero;
        logic exp_max;
        logic mant_nz;
        logic half_ok;
        logic single_ok;
    } t_class;

endpackage

// ===== sv/double_to_shortest_float_encoder.sv =====
// ----------------------------------------------------------------------------
// double_to_shortest_float_encoder
// picks the shortest exact encoding of a double and reports tag and payload
// ----------------------------------------------------------------------------
// Three-stage pipeline: classify, build payload, fit check and tag select.
// One value is taken every cycle unless the output stalls; each result passes
// through the stage registers in turn. A stall holds the full stages queued
// behind the output; bubbles are squeezed out so the input stays ready while
// any stage is empty. Tag registers are written through the config channel,
// which is always ready; write them only while the pipeline is drained.
module double_to_shortest_float_encoder
    import dsfe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [63:0] i_value_bits,
    input  logic [3:0]  i_space_left,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_tag_byte,
    output logic [63:0] o_payload,
    output logic [3:0]  o_payload_bytes,
    output logic [3:0]  o_bytes_written
);

    // config registers
    logic [7:0] r_tag_zero, r_tag_half, r_tag_single, r_tag_double;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_zero   <= TAG_ZERO_RST;
            r_tag_half   <= TAG_HALF_RST;
            r_tag_single <= TAG_SINGLE_RST;
            r_tag_double <= TAG_DOUBLE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TAG_ZERO:   r_tag_zero   <= i_cfg_data;
                CFG_TAG_HALF:   r_tag_half   <= i_cfg_data;
                CFG_TAG_SINGLE: r_tag_single <= i_cfg_data;
                CFG_TAG_DOUBLE: r_tag_double <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage valids and advance enables
    logic r_v1, r_v2, r_v3;
    logic adv1, adv2, adv3;

    assign adv3       = !r_v3 || i_out_ready;
    assign adv2       = !r_v2 || adv3;
    assign adv1       = !r_v1 || adv2;
    assign o_in_ready = adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_in_valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
        end
    end

    // stage 1: classify
    logic [10:0] in_expf;
    t_class      n_cls;
    t_class      r_cls1;
    logic [63:0] r_bits1;
    logic [3:0]  r_room1;

    assign in_expf = i_value_bits[62:52];

    always_comb begin
        n_cls.abs_zero  = (i_value_bits[62:0] == 63'd0);
        n_cls.exp_max   = &in_expf;
        n_cls.mant_nz   = |i_value_bits[51:0];
        n_cls.half_ok   = (in_expf >= HALF_EXP_MIN) && (in_expf <= HALF_EXP_MAX)
                          && (i_value_bits[41:0] == 42'd0);
        n_cls.single_ok = (in_expf >= SINGLE_EXP_MIN) && (in_expf <= SINGLE_EXP_MAX)
                          && (i_value_bits[28:0] == 29'd0);
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_cls1  <= n_cls;
            r_bits1 <= i_value_bits;
            r_room1 <= i_space_left;
        end
    end

    // stage 2: build payload
    logic [10:0] half_exp, single_exp;
    t_kind       n_kind2;
    logic [63:0] n_payload2;
    logic [3:0]  n_pbytes2;
    t_kind       r_kind2;
    logic [63:0] r_payload2;
    logic [3:0]  r_pbytes2;
    logic [3:0]  r_room2;

    assign half_exp   = r_bits1[62:52] - HALF_REBIAS;
    assign single_exp = r_bits1[62:52] - SINGLE_REBIAS;

    always_comb begin
        if (r_cls1.abs_zero) begin
            n_kind2    = KIND_ZERO;
            n_payload2 = 64'd0;
            n_pbytes2  = PBYTES_ZERO;
        end else if (r_cls1.exp_max) begin
            n_kind2   = KIND_HALF;
            n_pbytes2 = PBYTES_HALF;
            if (r_cls1.mant_nz) begin
                n_payload2 = {48'd0, HALF_NAN};
            end else if (r_bits1[63]) begin
                n_payload2 = {48'd0, HALF_NEG_INF};
            end else begin
                n_payload2 = {48'd0, HALF_POS_INF};
            end
        end else if (r_cls1.half_ok) begin
            n_kind2    = KIND_HALF;
            n_pbytes2  = PBYTES_HALF;
            n_payload2 = {48'd0, r_bits1[63], half_exp[4:0], r_bits1[51:42]};
        end else if (r_cls1.single_ok) begin
            n_kind2    = KIND_SINGLE;
            n_pbytes2  = PBYTES_SINGLE;
            n_payload2 = {32'd0, r_bits1[63], single_exp[7:0], r_bits1[51:29]};
        end else begin
            n_kind2    = KIND_DOUBLE;
            n_pbytes2  = PBYTES_DOUBLE;
            n_payload2 = r_bits1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r_kind2    <= n_kind2;
            r_payload2 <= n_payload2;
            r_pbytes2  <= n_pbytes2;
            r_room2    <= r_room1;
        end
    end

    // stage 3: fit check and tag select
    logic [4:0]  need_bytes;
    logic        fits;
    logic [7:0]  sel_tag;
    logic [7:0]  r_tag3;
    logic [63:0] r_payload3;
    logic [3:0]  r_pbytes3;
    logic [3:0]  r_written3;

    assign need_bytes = {1'b0, r_pbytes2} + 5'd1;
    assign fits       = {1'b0, r_room2} >= need_bytes;

    always_comb begin
        unique case (r_kind2)
            KIND_ZERO:   sel_tag = r_tag_zero;
            KIND_HALF:   sel_tag = r_tag_half;
            KIND_SINGLE: sel_tag = r_tag_single;
            KIND_DOUBLE: sel_tag = r_tag_double;
            default:     sel_tag = r_tag_double;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv3) begin
            if (fits) begin
                r_tag3     <= sel_tag;
                r_payload3 <= r_payload2;
                r_pbytes3  <= r_pbytes2;
                r_written3 <= need_bytes[3:0];
            end else begin
                r_tag3     <= 8'd0;
                r_payload3 <= 64'd0;
                r_pbytes3  <= 4'd0;
                r_written3 <= 4'd0;
            end
        end
    end

    assign o_out_valid     = r_v3;
    assign o_tag_byte      = r_tag3;
    assign o_payload       = r_payload3;
    assign o_payload_bytes = r_pbytes3;
    assign o_bytes_written = r_written3;

endmodule
